// ===== sv/apr_pkg.sv =====
// Shared types, constants and saturating arithmetic of the affine point/rectangle mapper.
package apr_pkg;

    // Coordinate format: signed fixed point, COORD_WIDTH bits, FRAC_BITS fraction bits
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 2 * COORD_WIDTH;

    // Configuration port geometry
    localparam int DATA_W    = (COORD_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_LSB  = (COORD_WIDTH > 32) ? 3 : 2;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = ADDR_LSB + REG_IDX_W;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_XX = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_XY = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_XT = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_YX = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_YY = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_YT = REG_IDX_W'(5);

    // Operation codes
    localparam logic FUNC_POINT = 1'b0;
    localparam logic FUNC_RECT  = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]      t_prod;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord COORD_ONE = COORD_WIDTH'(64'sd1 <<< FRAC_BITS);

    typedef struct packed {
        logic   func;
        t_coord in_x;
        t_coord in_y;
        t_coord in_w;
        t_coord in_h;
    } t_in;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_w;
        t_coord out_h;
    } t_out;

    typedef struct packed {
        t_coord xx;
        t_coord xy;
        t_coord xt;
        t_coord yx;
        t_coord yy;
        t_coord yt;
    } t_coefs;

    // Exact signed product of two coordinates
    function automatic t_prod mul_exact(input t_coord a, input t_coord b);
        t_prod ea;
        t_prod eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    // Shift a product down by the fraction bits (toward minus infinity) and saturate
    function automatic t_coord sat_prod(input t_prod p);
        t_prod                          s;
        logic [PROD_W-COORD_WIDTH:0]    top;
        s   = p >>> FRAC_BITS;
        top = s[PROD_W-1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            return s[COORD_WIDTH-1:0];
        end else if (top[PROD_W-COORD_WIDTH]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

    // Sum three coordinates exactly and saturate once
    function automatic t_coord sat_sum3(input t_coord a, input t_coord b, input t_coord c);
        logic signed [COORD_WIDTH+1:0] ea;
        logic signed [COORD_WIDTH+1:0] eb;
        logic signed [COORD_WIDTH+1:0] ec;
        logic signed [COORD_WIDTH+1:0] s;
        ea = a;
        eb = b;
        ec = c;
        s  = ea + eb + ec;
        if ((&s[COORD_WIDTH+1:COORD_WIDTH-1]) || !(|s[COORD_WIDTH+1:COORD_WIDTH-1])) begin
            return s[COORD_WIDTH-1:0];
        end else if (s[COORD_WIDTH+1]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

    // Sum two coordinates and saturate
    function automatic t_coord sat_sum2(input t_coord a, input t_coord b);
        logic signed [COORD_WIDTH:0] ea;
        logic signed [COORD_WIDTH:0] eb;
        logic signed [COORD_WIDTH:0] s;
        ea = a;
        eb = b;
        s  = ea + eb;
        if (s[COORD_WIDTH] == s[COORD_WIDTH-1]) begin
            return s[COORD_WIDTH-1:0];
        end else if (s[COORD_WIDTH]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

    // Span from hi down to lo (hi >= lo), saturated to the largest positive value
    function automatic t_coord span(input t_coord hi, input t_coord lo);
        logic signed [COORD_WIDTH:0] ehi;
        logic signed [COORD_WIDTH:0] elo;
        logic signed [COORD_WIDTH:0] d;
        ehi = hi;
        elo = lo;
        d   = ehi - elo;
        if (d[COORD_WIDTH-1]) begin
            return COORD_MAX;
        end else begin
            return d[COORD_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== sv/apr_regs.sv =====
// Coefficient register file behind the APB-style configuration port.
module apr_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apr_pkg::ADDR_W-1:0]   paddr,
    input  logic [apr_pkg::DATA_W-1:0]   pwdata,
    output logic [apr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output apr_pkg::t_coefs              o_coefs
);
    import apr_pkg::*;

    t_coefs                 r_coefs;
    logic                   w_wr;
    logic [REG_IDX_W-1:0]   w_idx;
    t_coord                 w_val;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite && pready;
    assign w_idx   = paddr[ADDR_W-1:ADDR_LSB];
    assign w_val   = pwdata[COORD_WIDTH-1:0];
    assign o_coefs = r_coefs;

    // Write one coefficient; indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.xx <= COORD_ONE;
            r_coefs.xy <= '0;
            r_coefs.xt <= '0;
            r_coefs.yx <= '0;
            r_coefs.yy <= COORD_ONE;
            r_coefs.yt <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_XX:  r_coefs.xx <= w_val;
                REG_XY:  r_coefs.xy <= w_val;
                REG_XT:  r_coefs.xt <= w_val;
                REG_YX:  r_coefs.yx <= w_val;
                REG_YY:  r_coefs.yy <= w_val;
                REG_YT:  r_coefs.yt <= w_val;
                default: ;
            endcase
        end
    end

    // Read back, sign-extended to the bus width
    always_comb begin
        case (w_idx)
            REG_XX:  prdata = DATA_W'(r_coefs.xx);
            REG_XY:  prdata = DATA_W'(r_coefs.xy);
            REG_XT:  prdata = DATA_W'(r_coefs.xt);
            REG_YX:  prdata = DATA_W'(r_coefs.yx);
            REG_YY:  prdata = DATA_W'(r_coefs.yy);
            REG_YT:  prdata = DATA_W'(r_coefs.yt);
            default: prdata = '0;
        endcase
    end

    a_wr_xx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && (w_idx == REG_XX)) |=> (r_coefs.xx == $past(w_val)))
        else $error("coef_xx write lost");

endmodule

// ===== sv/apr_map.sv =====
// Front pipeline: input register, far edges, eight products and the mapped corners.
module apr_map (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  apr_pkg::t_in    i_item,
    input  apr_pkg::t_coefs i_coefs,
    output logic            o_valid,
    output logic            o_func,
    output apr_pkg::t_coord o_cx [4],
    output apr_pkg::t_coord o_cy [4]
);
    import apr_pkg::*;

    // Corner order: (x,y) (x2,y) (x2,y2) (x,y2); which x and y column each uses
    localparam logic [3:0] CORNER_XSEL = 4'b0110;
    localparam logic [3:0] CORNER_YSEL = 4'b1100;

    // Stage 1: registered input item
    logic   r_v1;
    t_in    r_s1;
    // Stage 2: near and far edges
    logic   r_v2;
    logic   r_f2;
    t_coord r_xe [2];
    t_coord r_ye [2];
    // Stage 3: raw products
    logic   r_v3;
    logic   r_f3;
    t_prod  r_pxx [2];
    t_prod  r_pxy [2];
    t_prod  r_pyx [2];
    t_prod  r_pyy [2];
    // Stage 4: mapped corners
    logic   r_v4;
    logic   r_f4;
    t_coord r_cx [4];
    t_coord r_cy [4];

    // Advance valid bits every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Capture the item; form the far edges x + w and y + h
    always_ff @(posedge i_clk) begin
        r_s1    <= i_item;
        r_f2    <= r_s1.func;
        r_xe[0] <= r_s1.in_x;
        r_xe[1] <= sat_sum2(r_s1.in_x, r_s1.in_w);
        r_ye[0] <= r_s1.in_y;
        r_ye[1] <= sat_sum2(r_s1.in_y, r_s1.in_h);
    end

    // Multiply each coefficient by both edges of its coordinate
    always_ff @(posedge i_clk) begin
        r_f3 <= r_f2;
        for (int i = 0; i < 2; i++) begin
            r_pxx[i] <= mul_exact(i_coefs.xx, r_xe[i]);
            r_pxy[i] <= mul_exact(i_coefs.xy, r_ye[i]);
            r_pyx[i] <= mul_exact(i_coefs.yx, r_xe[i]);
            r_pyy[i] <= mul_exact(i_coefs.yy, r_ye[i]);
        end
    end

    // Scale, add translation and saturate per corner
    always_ff @(posedge i_clk) begin
        r_f4 <= r_f3;
        for (int i = 0; i < 4; i++) begin
            r_cx[i] <= sat_sum3(sat_prod(r_pxx[CORNER_XSEL[i]]),
                                sat_prod(r_pxy[CORNER_YSEL[i]]), i_coefs.xt);
            r_cy[i] <= sat_sum3(sat_prod(r_pyx[CORNER_XSEL[i]]),
                                sat_prod(r_pyy[CORNER_YSEL[i]]), i_coefs.yt);
        end
    end

    assign o_valid = r_v4;
    assign o_func  = r_f4;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;

endmodule

// ===== sv/apr_bbox.sv =====
// Back pipeline: corner minimum/maximum, then box width and height into the result register.
module apr_bbox (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_func,
    input  apr_pkg::t_coord i_cx [4],
    input  apr_pkg::t_coord i_cy [4],
    output logic            o_valid,
    output apr_pkg::t_out   o_result
);
    import apr_pkg::*;

    t_coord w_lox01, w_lox23, w_hix01, w_hix23;
    t_coord w_loy01, w_loy23, w_hiy01, w_hiy23;
    t_coord w_minx, w_maxx, w_miny, w_maxy;

    logic   r_v5;
    t_coord r_minx, r_maxx, r_miny, r_maxy;
    logic   r_done;
    t_out   r_out;

    // Two-level compare tree over the four corners
    always_comb begin
        w_lox01 = (i_cx[1] < i_cx[0]) ? i_cx[1] : i_cx[0];
        w_lox23 = (i_cx[3] < i_cx[2]) ? i_cx[3] : i_cx[2];
        w_hix01 = (i_cx[1] > i_cx[0]) ? i_cx[1] : i_cx[0];
        w_hix23 = (i_cx[3] > i_cx[2]) ? i_cx[3] : i_cx[2];
        w_loy01 = (i_cy[1] < i_cy[0]) ? i_cy[1] : i_cy[0];
        w_loy23 = (i_cy[3] < i_cy[2]) ? i_cy[3] : i_cy[2];
        w_hiy01 = (i_cy[1] > i_cy[0]) ? i_cy[1] : i_cy[0];
        w_hiy23 = (i_cy[3] > i_cy[2]) ? i_cy[3] : i_cy[2];
        w_minx  = (w_lox23 < w_lox01) ? w_lox23 : w_lox01;
        w_maxx  = (w_hix23 > w_hix01) ? w_hix23 : w_hix01;
        w_miny  = (w_loy23 < w_loy01) ? w_loy23 : w_loy01;
        w_maxy  = (w_hiy23 > w_hiy01) ? w_hiy23 : w_hiy01;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v5   <= i_valid;
            r_done <= r_v5;
        end
    end

    // Hold the box extent; a point collapses to its own mapped position
    always_ff @(posedge i_clk) begin
        if (i_func == FUNC_RECT) begin
            r_minx <= w_minx;
            r_maxx <= w_maxx;
            r_miny <= w_miny;
            r_maxy <= w_maxy;
        end else begin
            r_minx <= i_cx[0];
            r_maxx <= i_cx[0];
            r_miny <= i_cy[0];
            r_maxy <= i_cy[0];
        end
    end

    // Form the result item
    always_ff @(posedge i_clk) begin
        r_out.out_x <= r_minx;
        r_out.out_y <= r_miny;
        r_out.out_w <= span(r_maxx, r_minx);
        r_out.out_h <= span(r_maxy, r_miny);
    end

    assign o_valid  = r_done;
    assign o_result = r_out;

    a_ext_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> ((r_minx <= r_maxx) && (r_miny <= r_maxy)))
        else $error("box minimum above maximum");

    a_size_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_out.out_w[COORD_WIDTH-1] && !r_out.out_h[COORD_WIDTH-1]))
        else $error("negative box size");

endmodule

// ===== sv/affine_point_rect_mapper.sv =====
// Top level of the affine point/rectangle mapper: config registers and the mapping pipeline.
//
// Each item is mapped by the 2x3 matrix held in the six coefficient registers (signed
// fixed point). func 0 returns the mapped point with zero width and height; func 1 maps
// the four corners of the rectangle and returns their bounding box (minimum x, minimum y,
// width, height). The block is a six-stage pipeline with no feedback: one item is taken
// every clock cycle, busy stays low, and each result appears on o_result for one cycle
// with o_done high after its item has passed through all stages, in acceptance order. The
// receiver cannot hold results off. The multiply stage (eight 32x32 products in parallel)
// and the corner compare tree set the stage depth. The user must write coefficients over the
// APB port while no item is in flight; the block does not check this. pready is always high.
module affine_point_rect_mapper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  apr_pkg::t_in                 i_item,
    output logic                         o_done,
    output apr_pkg::t_out                o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apr_pkg::ADDR_W-1:0]   paddr,
    input  logic [apr_pkg::DATA_W-1:0]   pwdata,
    output logic [apr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import apr_pkg::*;

    t_coefs w_coefs;
    logic   w_accept;
    logic   w_map_valid;
    logic   w_map_func;
    t_coord w_cx [4];
    t_coord w_cy [4];

    // The pipeline never stalls
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    apr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (w_coefs)
    );

    apr_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .i_coefs (w_coefs),
        .o_valid (w_map_valid),
        .o_func  (w_map_func),
        .o_cx    (w_cx),
        .o_cy    (w_cy)
    );

    apr_bbox u_bbox (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_map_valid),
        .i_func   (w_map_func),
        .i_cx     (w_cx),
        .i_cy     (w_cy),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, 6))
        else $error("result without a matching item");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the affine point/rectangle mapper: stimulus, predictor, checker.
`timescale 1ns / 100ps

module testbench;
    import apr_pkg::*;

    localparam int PIPE_LATENCY = 6;
    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASES       = 8;
    localparam int ITEMS_PER_PH = 200;

    // Register slots past the matrix; writes there must leave the matrix alone
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = REG_IDX_W'(7);

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    t_in                 i_item  = '0;
    logic                o_done;
    t_out                o_result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    t_in    pending_items [$];
    t_out   bbox_expected [$];
    t_coord coef_model [0:5];
    int     gap_pct      = 0;
    int     mismatches   = 0;
    int     points_done  = 0;
    int     rects_done   = 0;
    int     results_seen = 0;
    int     quiet_cycles = 0;

    affine_point_rect_mapper u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 i_clk = ~i_clk;

    // Clamp a wide value to the coordinate range
    function automatic t_coord clamp_coord(input longint v);
        if (v > longint'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (v < longint'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return t_coord'(v);
    endfunction

    // Fixed-point product: exact, floor shift, then clamp
    function automatic t_coord scale_mul(input t_coord c, input t_coord v);
        longint p;
        p = longint'(c) * longint'(v);
        return clamp_coord(p >>> FRAC_BITS);
    endfunction

    // Map one point through the matrix row (cx, cy, ct)
    function automatic t_coord map_axis(input t_coord cx, input t_coord cy, input t_coord ct,
                                       input t_coord x, input t_coord y);
        return clamp_coord(longint'(scale_mul(cx, x)) + longint'(scale_mul(cy, y))
                           + longint'(ct));
    endfunction

    // Predict the mapped point, or the bounding box of the four mapped corners
    function automatic t_out predict_box(input t_in it);
        t_out   r;
        t_coord xs [0:3];
        t_coord ys [0:3];
        t_coord mx [0:3];
        t_coord my [0:3];
        t_coord x2;
        t_coord y2;
        t_coord lo_x;
        t_coord hi_x;
        t_coord lo_y;
        t_coord hi_y;
        x2 = clamp_coord(longint'(it.in_x) + longint'(it.in_w));
        y2 = clamp_coord(longint'(it.in_y) + longint'(it.in_h));
        xs = '{it.in_x, x2, x2, it.in_x};
        ys = '{it.in_y, it.in_y, y2, y2};
        for (int k = 0; k < 4; k++) begin
            mx[k] = map_axis(coef_model[REG_XX], coef_model[REG_XY], coef_model[REG_XT],
                             xs[k], ys[k]);
            my[k] = map_axis(coef_model[REG_YX], coef_model[REG_YY], coef_model[REG_YT],
                             xs[k], ys[k]);
        end
        if (it.func == FUNC_POINT) begin
            r.out_x = mx[0];
            r.out_y = my[0];
            r.out_w = '0;
            r.out_h = '0;
            return r;
        end
        lo_x = mx[0];
        hi_x = mx[0];
        lo_y = my[0];
        hi_y = my[0];
        for (int k = 1; k < 4; k++) begin
            if (mx[k] < lo_x) lo_x = mx[k];
            if (mx[k] > hi_x) hi_x = mx[k];
            if (my[k] < lo_y) lo_y = my[k];
            if (my[k] > hi_y) hi_y = my[k];
        end
        r.out_x = lo_x;
        r.out_y = lo_y;
        r.out_w = clamp_coord(longint'(hi_x) - longint'(lo_x));
        r.out_h = clamp_coord(longint'(hi_y) - longint'(lo_y));
        return r;
    endfunction

    function automatic t_in make_item(input logic f, input t_coord x, input t_coord y,
                                      input t_coord w, input t_coord h);
        t_in it;
        it.func = f;
        it.in_x = x;
        it.in_y = y;
        it.in_w = w;
        it.in_h = h;
        return it;
    endfunction

    // Mix of full-range, near-origin and boundary coordinates
    function automatic t_coord rand_coord();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4) begin
            return t_coord'($urandom);
        end else if (pick < 8) begin
            return t_coord'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        end
        case ($urandom_range(5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return -t_coord'(1);
            4: return t_coord'(1);
            default: return COORD_ONE;
        endcase
    endfunction

    // Coefficient within +-8.0, or anywhere in range
    function automatic t_coord rand_coef(input bit full_range);
        if (full_range) begin
            return t_coord'($urandom);
        end
        return t_coord'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input t_coord val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << ADDR_LSB;
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_YT) coef_model[idx] = val;
    endtask

    task automatic apb_check(input logic [REG_IDX_W-1:0] idx);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx) << ADDR_LSB;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (t_coord'(prdata) !== coef_model[idx]) begin
            mismatches++;
            $display("%0t: register %0d readback expected %0d got %0d",
                     $time, idx, coef_model[idx], $signed(prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_matrix();
        apb_check(REG_XX);
        apb_check(REG_XY);
        apb_check(REG_XT);
        apb_check(REG_YX);
        apb_check(REG_YY);
        apb_check(REG_YT);
    endtask

    task automatic load_matrix(input t_coord xx, input t_coord xy, input t_coord xt,
                               input t_coord yx, input t_coord yy, input t_coord yt);
        apb_write(REG_XX, xx);
        apb_write(REG_XY, xy);
        apb_write(REG_XT, xt);
        apb_write(REG_YX, yx);
        apb_write(REG_YY, yy);
        apb_write(REG_YT, yt);
        check_matrix();
    endtask

    // Hold until every queued item is accepted and every result has come back
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || bbox_expected.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input t_coord want, input t_coord got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Drive items from the pending queue; hold the current one until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                bbox_expected.push_back(predict_box(i_item));
                if (i_item.func == FUNC_RECT) rects_done++;
                else points_done++;
            end
            if (!start || !busy) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    start  <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (bbox_expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result expected none got %h", $time, o_result);
            end else begin
                t_out want;
                want = bbox_expected.pop_front();
                check_field("out_x", want.out_x, o_result.out_x);
                check_field("out_y", want.out_y, o_result.out_y);
                check_field("out_w", want.out_w, o_result.out_w);
                check_field("out_h", want.out_h, o_result.out_h);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done || (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        coef_model = '{COORD_ONE, '0, '0, '0, COORD_ONE, '0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_matrix();

        for (int ph = 0; ph < PHASES; ph++) begin
            // Pick a coefficient setting; phase 0 keeps the identity from reset
            case (ph)
                1: load_matrix(rand_coef(0), rand_coef(0), rand_coef(0),
                               rand_coef(0), rand_coef(0), rand_coef(0));
                2: load_matrix(COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX, COORD_MAX, COORD_MAX);
                3: load_matrix(COORD_MIN, COORD_MIN, COORD_MIN,
                               COORD_MIN, COORD_MIN, COORD_MIN);
                4: load_matrix(rand_coef(1), rand_coef(1), rand_coef(1),
                               rand_coef(1), rand_coef(1), rand_coef(1));
                5: load_matrix('0, COORD_ONE, rand_coef(0),
                               -COORD_ONE, '0, rand_coef(0));
                6: begin
                    load_matrix(COORD_MIN, COORD_MAX, COORD_MIN,
                                COORD_MAX, COORD_MIN, COORD_MAX);
                    // Writes past the matrix must be dropped
                    apb_write(REG_SPARE_LO, t_coord'($urandom));
                    apb_write(REG_SPARE_HI, t_coord'($urandom));
                    check_matrix();
                end
                7: load_matrix(rand_coef(0), rand_coef(1), rand_coef(0),
                               rand_coef(1), rand_coef(0), rand_coef(1));
                default: ;
            endcase

            case (ph % 4)
                1: gap_pct = 50;
                3: gap_pct = 25;
                default: gap_pct = 0;
            endcase

            if (ph == 0) begin
                // Points, with size fields that must be ignored
                pending_items.push_back(make_item(FUNC_POINT, '0, '0, COORD_MAX, COORD_MIN));
                pending_items.push_back(make_item(FUNC_POINT, COORD_MAX, COORD_MAX, '0, '0));
                pending_items.push_back(make_item(FUNC_POINT, COORD_MIN, COORD_MIN,
                                                  COORD_MIN, COORD_MAX));
                pending_items.push_back(make_item(FUNC_POINT, -t_coord'(1), t_coord'(1),
                                                  t_coord'(-1), t_coord'(-1)));
                pending_items.push_back(make_item(FUNC_POINT, COORD_ONE, -COORD_ONE,
                                                  t_coord'($urandom), t_coord'($urandom)));
                // Rectangles: plain, negative size, saturating corners, widest span
                pending_items.push_back(make_item(FUNC_RECT, '0, '0, COORD_ONE, COORD_ONE));
                pending_items.push_back(make_item(FUNC_RECT, 10 * COORD_ONE, 10 * COORD_ONE,
                                                  -3 * COORD_ONE, -5 * COORD_ONE));
                pending_items.push_back(make_item(FUNC_RECT, COORD_MAX - 5, COORD_MAX,
                                                  COORD_MAX, COORD_MAX));
                pending_items.push_back(make_item(FUNC_RECT, COORD_MIN, COORD_MIN,
                                                  COORD_MIN, COORD_MIN));
                pending_items.push_back(make_item(FUNC_RECT, COORD_MIN, '0,
                                                  COORD_MAX, -t_coord'(1)));
                pending_items.push_back(make_item(FUNC_RECT, COORD_MAX, COORD_MIN,
                                                  COORD_MIN, COORD_MAX));
                pending_items.push_back(make_item(FUNC_RECT, '0, '0, '0, '0));
                pending_items.push_back(make_item(FUNC_RECT, -t_coord'(1), t_coord'(1),
                                                  COORD_MIN, COORD_MAX));
            end

            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                pending_items.push_back(make_item(logic'($urandom_range(1)), rand_coord(),
                                                  rand_coord(), rand_coord(), rand_coord()));
            end
            // Sender pauses here until the pipeline is empty
            drain();
        end

        if (bbox_expected.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, bbox_expected.size());
        end
        $display("Mapped %0d points and %0d rectangles, %0d results checked, %0d mismatches",
                 points_done, rects_done, results_seen, mismatches);
        $display("Coverage: identity, random, saturating and mixed matrices, %s",
                 "spare register writes, sender gaps of 0, 25 and 50 percent");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
